@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: implication");

// The condition must never be true.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");

`endif

@@ hw/rtl/cau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Types, widths and helper functions shared by the pipeline modules.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DW    = 16;        // operand and result width
	localparam int FB    = 8;         // fraction bits
	localparam int PW    = 2 * DW;    // product width
	localparam int SW    = PW + 1;    // width of a sum of two products
	localparam int RW    = PW + 1;    // divider remainder width
	localparam int SRW   = DW + 3;    // square root remainder width
	localparam int NSTEP = DW;        // quotient bits and root bits per item

	localparam logic [SW-1:0] POS_MAX = SW'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic [SW-1:0] NEG_MAG = SW'(64'd1 << (DW - 1));
	localparam logic [SW-1:0] RND_HALF = SW'(64'd1 << (FB - 1));

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_MUL  = 3'd1,
		OP_DIV  = 3'd2,
		OP_MAG  = 3'd3,
		OP_CONJ = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]            opcode;
		logic signed [DW-1:0]  a_real;
		logic signed [DW-1:0]  a_imag;
		logic signed [DW-1:0]  b_real;
		logic signed [DW-1:0]  b_imag;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0]  res_real;
		logic signed [DW-1:0]  res_imag;
		logic [1:0]            status;
	} res_t;

	// State carried through the divide and square root steps.
	typedef struct packed {
		logic                  valid;
		logic [2:0]            op;
		logic signed [SW-1:0]  sum_re;
		logic signed [SW-1:0]  sum_im;
		logic                  big_re;
		logic                  big_im;
		logic [PW-1:0]         den;
		logic [RW-1:0]         rem_re;
		logic [RW-1:0]         rem_im;
		logic [DW-1:0]         dlo_re;
		logic [DW-1:0]         dlo_im;
		logic [DW-1:0]         q_re;
		logic [DW-1:0]         q_im;
		logic [PW-1:0]         sq_n;
		logic [SRW-1:0]        sq_rem;
		logic [DW-1:0]         sq_root;
	} pipe_t;

	// Returns {saturated, value} for a sign and magnitude.
	function automatic logic [DW:0] sat_part(input logic neg, input logic [SW-1:0] mag);
		logic [DW:0]   r;
		logic [DW-1:0] neg_val;
		neg_val = '0 - mag[DW-1:0];
		if (!neg && mag > POS_MAX) begin
			r = {1'b1, 1'b0, {(DW-1){1'b1}}};
		end else if (neg && mag > NEG_MAG) begin
			r = {1'b1, 1'b1, {(DW-1){1'b0}}};
		end else if (neg) begin
			r = {1'b0, neg_val};
		end else begin
			r = {1'b0, mag[DW-1:0]};
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/cau_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Input register, products, sums, and divider and square root setup.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  req_t  in_req,
	output pipe_t out
);

	logic                  v_s1;
	req_t                  req_s1;

	logic                  v_s2;
	logic [2:0]            op_s2;
	logic signed [PW-1:0]  p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [DW:0]    e_re_s2, e_im_s2;

	logic                  v_s3;
	logic [2:0]            op_s3;
	logic signed [SW-1:0]  re_s3, im_s3;
	logic [PW-1:0]         den_s3;

	pipe_t                 pipe_s4;

	logic signed [DW-1:0]  y0, y1;
	logic signed [DW:0]    ar_x, ai_x, br_x, bi_x, e_re, e_im;
	logic signed [SW-1:0]  re_n, im_n;
	logic [PW-1:0]         den_n;
	logic [SW-1:0]         abs_re, abs_im;
	logic [SW+FB-1:0]      d_re, d_im;
	logic [PW+DW-1:0]      den_sh;
	pipe_t                 prep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Magnitude squares a itself; the other opcodes pair a with b.
	always_comb begin
		y0   = (req_s1.opcode == OP_MAG) ? req_s1.a_real : req_s1.b_real;
		y1   = (req_s1.opcode == OP_MAG) ? req_s1.a_imag : req_s1.b_imag;
		ar_x = {req_s1.a_real[DW-1], req_s1.a_real};
		ai_x = {req_s1.a_imag[DW-1], req_s1.a_imag};
		br_x = {req_s1.b_real[DW-1], req_s1.b_real};
		bi_x = {req_s1.b_imag[DW-1], req_s1.b_imag};
		if (req_s1.opcode == OP_CONJ) begin
			e_re = ar_x;
			e_im = -ai_x;
		end else begin
			e_re = ar_x + br_x;
			e_im = ai_x + bi_x;
		end
	end

	always_ff @(posedge clk) begin
		req_s1  <= in_req;
		op_s2   <= req_s1.opcode;
		p0_s2   <= req_s1.a_real * y0;
		p1_s2   <= req_s1.a_imag * y1;
		p2_s2   <= req_s1.a_real * req_s1.b_imag;
		p3_s2   <= req_s1.a_imag * req_s1.b_real;
		p4_s2   <= req_s1.b_real * req_s1.b_real;
		p5_s2   <= req_s1.b_imag * req_s1.b_imag;
		e_re_s2 <= e_re;
		e_im_s2 <= e_im;
	end

	always_comb begin
		den_n = $unsigned(p4_s2) + $unsigned(p5_s2);
		case (op_s2)
			OP_ADD, OP_CONJ: begin
				re_n = SW'(e_re_s2);
				im_n = SW'(e_im_s2);
			end
			OP_MUL: begin
				re_n = SW'(p0_s2) - SW'(p1_s2);
				im_n = SW'(p2_s2) + SW'(p3_s2);
			end
			OP_DIV: begin
				re_n = SW'(p0_s2) + SW'(p1_s2);
				im_n = SW'(p3_s2) - SW'(p2_s2);
			end
			OP_MAG: begin
				re_n = SW'(p0_s2) + SW'(p1_s2);
				im_n = '0;
			end
			default: begin
				re_n = '0;
				im_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		re_s3  <= re_n;
		im_s3  <= im_n;
		den_s3 <= den_n;
	end

	// A quotient of 2^DW or more always saturates, so the divider only
	// needs DW quotient bits once that case is flagged.
	always_comb begin
		abs_re  = (re_s3 < 0) ? $unsigned(-re_s3) : $unsigned(re_s3);
		abs_im  = (im_s3 < 0) ? $unsigned(-im_s3) : $unsigned(im_s3);
		d_re    = {abs_re, {FB{1'b0}}};
		d_im    = {abs_im, {FB{1'b0}}};
		den_sh  = {den_s3, {DW{1'b0}}};
		prep.valid   = v_s3;
		prep.op      = op_s3;
		prep.sum_re  = re_s3;
		prep.sum_im  = im_s3;
		prep.big_re  = (PW+DW)'(d_re) >= den_sh;
		prep.big_im  = (PW+DW)'(d_im) >= den_sh;
		prep.den     = den_s3;
		prep.rem_re  = RW'(d_re[SW+FB-1:DW]);
		prep.rem_im  = RW'(d_im[SW+FB-1:DW]);
		prep.dlo_re  = d_re[DW-1:0];
		prep.dlo_im  = d_im[DW-1:0];
		prep.q_re    = '0;
		prep.q_im    = '0;
		prep.sq_n    = re_s3[PW-1:0];
		prep.sq_rem  = '0;
		prep.sq_root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s4 <= '0;
		end else begin
			pipe_s4 <= prep;
		end
	end

	assign out = pipe_s4;

endmodule

@@ hw/rtl/cau_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit iteration stage
// One quotient bit for each of the two dividers and one root bit per stage.
// ----------------------------------------------------------------------------
module cau_step import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  pipe_t in,
	output pipe_t out
);

	pipe_t             nx;
	pipe_t             pipe_s1;
	logic [RW-1:0]     rs_re, rs_im;
	logic              ge_re, ge_im, ge_sq;
	logic [SRW-1:0]    ss, trial;

	always_comb begin
		nx = in;

		rs_re     = {in.rem_re[RW-2:0], in.dlo_re[DW-1]};
		ge_re     = rs_re >= RW'(in.den);
		nx.rem_re = ge_re ? rs_re - RW'(in.den) : rs_re;
		nx.q_re   = {in.q_re[DW-2:0], ge_re};
		nx.dlo_re = {in.dlo_re[DW-2:0], 1'b0};

		rs_im     = {in.rem_im[RW-2:0], in.dlo_im[DW-1]};
		ge_im     = rs_im >= RW'(in.den);
		nx.rem_im = ge_im ? rs_im - RW'(in.den) : rs_im;
		nx.q_im   = {in.q_im[DW-2:0], ge_im};
		nx.dlo_im = {in.dlo_im[DW-2:0], 1'b0};

		// Digit-by-digit square root, two radicand bits per stage.
		ss         = {in.sq_rem[SRW-3:0], in.sq_n[PW-1:PW-2]};
		trial      = SRW'({in.sq_root, 2'b01});
		ge_sq      = ss >= trial;
		nx.sq_rem  = ge_sq ? ss - trial : ss;
		nx.sq_root = {in.sq_root[DW-2:0], ge_sq};
		nx.sq_n    = {in.sq_n[PW-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1 <= '0;
		end else begin
			pipe_s1 <= nx;
		end
	end

	assign out = pipe_s1;

endmodule

@@ hw/rtl/cau_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Rounding, saturation and status, then the result register.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  pipe_t in,
	output logic  done,
	output res_t  result
);

	logic              v_s1, dz_s1, neg_re_s1, neg_im_s1;
	logic [SW-1:0]     mag_re_s1, mag_im_s1;
	logic              v_s2;
	res_t              res_s2;

	logic [SW-1:0]     abs_re, abs_im;
	logic              inc_re, inc_im, dz;
	logic              neg_re, neg_im;
	logic [SW-1:0]     mag_re, mag_im;
	logic [DW:0]       sr, si;
	res_t              res_n;

	always_comb begin
		abs_re = (in.sum_re < 0) ? $unsigned(-in.sum_re) : $unsigned(in.sum_re);
		abs_im = (in.sum_im < 0) ? $unsigned(-in.sum_im) : $unsigned(in.sum_im);
		// Round to nearest with halves up: twice the remainder against the divisor.
		inc_re = {in.rem_re, 1'b0} >= (RW+1)'(in.den);
		inc_im = {in.rem_im, 1'b0} >= (RW+1)'(in.den);
		dz     = (in.op == OP_DIV) && (in.den == '0);
		neg_re = in.sum_re < 0;
		neg_im = in.sum_im < 0;
		case (in.op)
			OP_ADD, OP_CONJ: begin
				mag_re = abs_re;
				mag_im = abs_im;
			end
			OP_MUL: begin
				mag_re = (abs_re + RND_HALF) >> FB;
				mag_im = (abs_im + RND_HALF) >> FB;
			end
			OP_DIV: begin
				mag_re = in.big_re ? '1 : SW'(in.q_re) + SW'(inc_re);
				mag_im = in.big_im ? '1 : SW'(in.q_im) + SW'(inc_im);
			end
			OP_MAG: begin
				neg_re = 1'b0;
				neg_im = 1'b0;
				mag_re = SW'(in.sq_root);
				mag_im = '0;
			end
			default: begin
				neg_re = 1'b0;
				neg_im = 1'b0;
				mag_re = '0;
				mag_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dz_s1     <= dz;
		neg_re_s1 <= neg_re;
		neg_im_s1 <= neg_im;
		mag_re_s1 <= mag_re;
		mag_im_s1 <= mag_im;
	end

	always_comb begin
		sr = sat_part(neg_re_s1, mag_re_s1);
		si = sat_part(neg_im_s1, mag_im_s1);
		if (dz_s1) begin
			res_n.res_real = '0;
			res_n.res_imag = '0;
			res_n.status   = ST_DZ;
		end else begin
			res_n.res_real = sr[DW-1:0];
			res_n.res_imag = si[DW-1:0];
			res_n.status   = (sr[DW] || si[DW]) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_n;
	end

	assign done   = v_s2;
	assign result = res_s2;

endmodule

@@ hw/rtl/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// A result passes the front-end, step and back-end registers before done rises.
// Throughput: one request per cycle; busy stays low, so start is always taken.
// The sixteen divide and square root steps, one bit per stage, set the depth.
// Reset clears every valid bit; no result is pending after reset.
// The receiver cannot stall, so done is a one-cycle strobe per request.
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined add, multiply, divide, magnitude and conjugate on Q8.8 operands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_arithmetic_unit import cau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t result
);

	localparam int LAT = NSTEP + 6;

	pipe_t chain [NSTEP+1];

	assign busy = 1'b0;

	cau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_valid (start),
		.in_req (req),
		.out    (chain[0])
	);

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		cau_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.in     (chain[k]),
			.out    (chain[k+1])
		);
	end

	cau_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (chain[NSTEP]),
		.done   (done),
		.result (result)
	);

	`ASSERT_IMPLIES(a_done_has_request, clk, arst_n, done, $past(start, LAT))
	`ASSERT_NEVER(a_dz_gives_zero, clk, arst_n,
		done && result.status == ST_DZ && (result.res_real != '0 || result.res_imag != '0))
	`ASSERT_IMPLIES(a_sat_at_limit, clk, arst_n, done && result.status == ST_SAT,
		result.res_real == {1'b0, {(DW-1){1'b1}}} || result.res_real == {1'b1, {(DW-1){1'b0}}}
		|| result.res_imag == {1'b0, {(DW-1){1'b1}}}
		|| result.res_imag == {1'b1, {(DW-1){1'b0}}})

endmodule
